>>> rtl/c2d_pkg.sv
`default_nettype none

package c2d_pkg;

  // store and size limits
  localparam int MAX_CHANNELS = 16;
  localparam int MAX_KERNEL   = 7;
  localparam int MAX_DIM      = 64;
  localparam int WEIGHT_DEPTH = 16384;
  localparam int IMAGE_DEPTH  = 65536;
  localparam int MAX_STRIDE   = 4;

  // fixed field widths
  localparam int CMD_W   = 2;
  localparam int INDEX_W = 16;
  localparam int VALUE_W = 16;
  localparam int OC_W    = 4;
  localparam int POS_W   = 6;
  localparam int RES_W   = 32;
  localparam int STAT_W  = 2;

  // configuration port
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_IN_CH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KSIZE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PADDING = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IN_H    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IN_W    = 3'd6;

  localparam logic [CMD_W-1:0] CMD_WEIGHT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BIAS    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_IMAGE   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_SAT   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  // derived internal widths
  localparam int CH_W   = $clog2(MAX_CHANNELS + 1);
  localparam int K_W    = $clog2(MAX_KERNEL + 1);
  localparam int S_W    = $clog2(MAX_STRIDE + 1);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int RS_W   = POS_W + S_W;
  localparam int SPAN_W = ((RS_W > DIM_W) ? RS_W : DIM_W) + 2;
  localparam int WIDX_W = $clog2(WEIGHT_DEPTH);
  localparam int IIDX_W = $clog2(IMAGE_DEPTH);
  localparam int BIDX_W = $clog2(MAX_CHANNELS);
  localparam int WA_W   =
    $clog2(MAX_CHANNELS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL + WEIGHT_DEPTH) + 1;
  localparam int IA_W   = $clog2(MAX_CHANNELS * MAX_DIM * MAX_DIM + IMAGE_DEPTH) + 2;
  localparam int ACC_W  = RES_W + $clog2(MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL + 1) + 1;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] value;
    logic [OC_W-1:0]           out_channel;
    logic [POS_W-1:0]          out_row;
    logic [POS_W-1:0]          out_col;
  } in_word_t;

  typedef struct packed {
    logic signed [RES_W-1:0] result;
    logic [STAT_W-1:0]       status;
  } out_word_t;

  function automatic logic [CH_W-1:0] clamp_ch(input logic [4:0] v);
    logic [CH_W-1:0] r;
    if (v == 5'd0) r = CH_W'(1);
    else if (int'(v) > MAX_CHANNELS) r = CH_W'(MAX_CHANNELS);
    else r = CH_W'(v);
    return r;
  endfunction

  function automatic logic [K_W-1:0] clamp_k(input logic [2:0] v);
    logic [K_W-1:0] r;
    if (v == 3'd0) r = K_W'(1);
    else if (int'(v) > MAX_KERNEL) r = K_W'(MAX_KERNEL);
    else r = K_W'(v);
    return r;
  endfunction

  function automatic logic [S_W-1:0] clamp_s(input logic [2:0] v);
    logic [S_W-1:0] r;
    if (v == 3'd0) r = S_W'(1);
    else if (int'(v) > MAX_STRIDE) r = S_W'(MAX_STRIDE);
    else r = S_W'(v);
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [6:0] v);
    logic [DIM_W-1:0] r;
    if (v == 7'd0) r = DIM_W'(1);
    else if (int'(v) > MAX_DIM) r = DIM_W'(MAX_DIM);
    else r = DIM_W'(v);
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/conv2d_stride_pad_mac.sv
`default_nettype none

// Direct 2-D convolution, one output element per compute word. Load words
// (weight, bias, image sample) write one store entry each and leave the
// sequencer idle. A compute word whose output channel, row or column lies
// outside the output size runs the setup states PREP0 and PREP1 and then
// returns the out-of-range status. A valid compute word runs the setup states
// PREP0, PREP1 and PREP2, then one kernel tap per cycle through a single shared
// 16x16 multiplier feeding a wide accumulator (input channels times kernel side
// squared taps, 784 at most), then the DRAIN state waits for the last read and
// product to reach the accumulator, and the DONE state saturates the sum into
// the output register once it is empty or being read. Taps in the zero border
// are still walked but add nothing. The block takes no new input word while a
// compute runs; a finished result waits in the output register while the next
// word is accepted. Stores are not cleared by reset, so every entry a compute
// touches must have been loaded first. Configuration is sampled when a compute
// word is accepted; out-of-range register values are clamped.
module conv2d_stride_pad_mac
  import c2d_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire in_word_t             in_word_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output out_word_t                 out_word_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP0 = 3'd1;
  localparam logic [2:0] S_PREP1 = 3'd2;
  localparam logic [2:0] S_PREP2 = 3'd3;
  localparam logic [2:0] S_RUN   = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam int OCMP_W  = CH_W + OC_W;
  localparam int OCICN_W = OC_W + CH_W;
  localparam int HW_W    = 2 * DIM_W;
  localparam int KK_W    = 2 * K_W;

  // configuration registers, raw as written
  logic [4:0] in_ch_q, out_ch_q;
  logic [2:0] ksize_q, stride_q;
  logic [1:0] pad_q;
  logic [6:0] in_h_q, in_w_q;

  logic [2:0] state_q, state_d;

  // compute operands sampled at accept
  logic [OC_W-1:0]  oc_q, oc_d;
  logic [POS_W-1:0] orow_q, orow_d, ocol_q, ocol_d;
  logic [CH_W-1:0]  icn_q, icn_d, ocn_q, ocn_d;
  logic [K_W-1:0]   k_q, k_d;
  logic [S_W-1:0]   s_q, s_d;
  logic [1:0]       p_q, p_d;
  logic [DIM_W-1:0] h_q, h_d, w_q, w_d;

  // setup products
  logic [RS_W-1:0]    rs_q, rs_d, cs_q, cs_d;
  logic [OCICN_W-1:0] ocicn_q, ocicn_d;
  logic [HW_W-1:0]    hw_q, hw_d;
  logic [KK_W-1:0]    kk_q, kk_d;
  logic signed [VALUE_W-1:0] bias_q, bias_d;
  logic               bad_q, bad_d;
  logic signed [SPAN_W-1:0] y0_q, y0_d, x0_q, x0_d;
  logic signed [IA_W-1:0]   y0w_q, y0w_d;

  // tap walk
  logic [WA_W-1:0]          wa_q, wa_d;
  logic signed [SPAN_W-1:0] y_q, y_d, x_q, x_d;
  logic signed [IA_W-1:0]   yrow_q, yrow_d, plane_q, plane_d;
  logic [CH_W-1:0]          ic_q, ic_d;
  logic [K_W-1:0]           ky_q, ky_d, kx_q, kx_d;

  // multiply-accumulate pipeline
  logic                      rd_vld_q, rd_vld_d;
  logic signed [VALUE_W-1:0] wrd_q, ird_q;
  logic                      prod_vld_q, prod_vld_d;
  logic signed [RES_W-1:0]   prod_q, prod_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;

  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q, out_word_d;

  // stores
  logic signed [VALUE_W-1:0] weight_mem [WEIGHT_DEPTH];
  logic signed [VALUE_W-1:0] image_mem  [IMAGE_DEPTH];
  logic signed [VALUE_W-1:0] bias_mem   [MAX_CHANNELS];

  logic in_fire, out_fire;
  logic wmem_we, imem_we, bmem_we;

  logic signed [SPAN_W-1:0] span_h, span_w;
  logic signed [IA_W-1:0]   ia, y0_ext, w_ext;
  logic                     tap_ok, sat_hi, sat_lo;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_fire    = out_valid_q && out_ready_i;

  // load words whose address falls beyond a store are dropped
  assign wmem_we = in_fire && (in_word_i.cmd == CMD_WEIGHT)
                   && (32'(in_word_i.index) < 32'(WEIGHT_DEPTH));
  assign imem_we = in_fire && (in_word_i.cmd == CMD_IMAGE)
                   && (32'(in_word_i.index) < 32'(IMAGE_DEPTH));
  assign bmem_we = in_fire && (in_word_i.cmd == CMD_BIAS)
                   && (32'(in_word_i.index) < 32'(MAX_CHANNELS));

  // output size check: row is inside when row*stride <= h + 2p - k
  assign span_h = $signed(SPAN_W'(h_q)) + $signed(SPAN_W'({p_q, 1'b0}))
                  - $signed(SPAN_W'(k_q));
  assign span_w = $signed(SPAN_W'(w_q)) + $signed(SPAN_W'({p_q, 1'b0}))
                  - $signed(SPAN_W'(k_q));

  assign y0_ext = IA_W'(y0_q);
  assign w_ext  = $signed(IA_W'(w_q));

  // image address of the current tap: plane + row offset + column
  assign ia = plane_q + yrow_q + IA_W'(x_q);

  // taps in the zero border, or beyond a store, contribute nothing
  assign tap_ok = !y_q[SPAN_W-1] && (y_q < $signed(SPAN_W'(h_q)))
                  && !x_q[SPAN_W-1] && (x_q < $signed(SPAN_W'(w_q)))
                  && (wa_q < WA_W'(WEIGHT_DEPTH))
                  && !ia[IA_W-1] && (ia < $signed(IA_W'(IMAGE_DEPTH)));

  assign sat_hi = acc_q > $signed({{(ACC_W-RES_W){1'b0}}, 1'b0, {(RES_W-1){1'b1}}});
  assign sat_lo = acc_q < $signed({{(ACC_W-RES_W){1'b1}}, 1'b1, {(RES_W-1){1'b0}}});

  always_comb begin
    state_d     = state_q;
    oc_d        = oc_q;
    orow_d      = orow_q;
    ocol_d      = ocol_q;
    icn_d       = icn_q;
    ocn_d       = ocn_q;
    k_d         = k_q;
    s_d         = s_q;
    p_d         = p_q;
    h_d         = h_q;
    w_d         = w_q;
    rs_d        = rs_q;
    cs_d        = cs_q;
    ocicn_d     = ocicn_q;
    hw_d        = hw_q;
    kk_d        = kk_q;
    bias_d      = bias_q;
    bad_d       = bad_q;
    y0_d        = y0_q;
    x0_d        = x0_q;
    y0w_d       = y0w_q;
    wa_d        = wa_q;
    y_d         = y_q;
    x_d         = x_q;
    yrow_d      = yrow_q;
    plane_d     = plane_q;
    ic_d        = ic_q;
    ky_d        = ky_q;
    kx_d        = kx_q;
    rd_vld_d    = 1'b0;
    prod_vld_d  = rd_vld_q;
    prod_d      = wrd_q * ird_q;
    acc_d       = prod_vld_q ? (acc_q + ACC_W'(prod_q)) : acc_q;
    out_valid_d = out_fire ? 1'b0 : out_valid_q;
    out_word_d  = out_word_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire && (in_word_i.cmd == CMD_COMPUTE)) begin
          // sample and clamp configuration for this compute
          oc_d    = in_word_i.out_channel;
          orow_d  = in_word_i.out_row;
          ocol_d  = in_word_i.out_col;
          icn_d   = clamp_ch(in_ch_q);
          ocn_d   = clamp_ch(out_ch_q);
          k_d     = clamp_k(ksize_q);
          s_d     = clamp_s(stride_q);
          p_d     = pad_q;
          h_d     = clamp_dim(in_h_q);
          w_d     = clamp_dim(in_w_q);
          state_d = S_PREP0;
        end
      end
      S_PREP0: begin
        rs_d    = RS_W'(orow_q) * RS_W'(s_q);
        cs_d    = RS_W'(ocol_q) * RS_W'(s_q);
        ocicn_d = OCICN_W'(oc_q) * OCICN_W'(icn_q);
        hw_d    = HW_W'(h_q) * HW_W'(w_q);
        kk_d    = KK_W'(k_q) * KK_W'(k_q);
        bias_d  = bias_mem[BIDX_W'(oc_q)];
        state_d = S_PREP1;
      end
      S_PREP1: begin
        bad_d = (OCMP_W'(oc_q) >= OCMP_W'(ocn_q))
                || span_h[SPAN_W-1] || ($signed(SPAN_W'(rs_q)) > span_h)
                || span_w[SPAN_W-1] || ($signed(SPAN_W'(cs_q)) > span_w);
        y0_d  = $signed(SPAN_W'(rs_q)) - $signed(SPAN_W'(p_q));
        x0_d  = $signed(SPAN_W'(cs_q)) - $signed(SPAN_W'(p_q));
        // weights of one filter are contiguous, so the tap walk just counts up
        wa_d  = WA_W'((OCICN_W + KK_W)'(ocicn_q) * (OCICN_W + KK_W)'(kk_q));
        // bias enters as Q16.16
        acc_d = ACC_W'(bias_q) <<< 8;
        state_d = bad_d ? S_DONE : S_PREP2;
      end
      S_PREP2: begin
        y0w_d   = y0_ext * w_ext;
        yrow_d  = y0_ext * w_ext;
        y_d     = y0_q;
        x_d     = x0_q;
        plane_d = '0;
        ic_d    = '0;
        ky_d    = '0;
        kx_d    = '0;
        state_d = S_RUN;
      end
      S_RUN: begin
        rd_vld_d = tap_ok;
        wa_d     = wa_q + WA_W'(1);
        if (kx_q == k_q - K_W'(1)) begin
          kx_d = '0;
          x_d  = x0_q;
          if (ky_q == k_q - K_W'(1)) begin
            ky_d   = '0;
            y_d    = y0_q;
            yrow_d = y0w_q;
            if (ic_q == icn_q - CH_W'(1)) begin
              state_d = S_DRAIN;
            end else begin
              ic_d    = ic_q + CH_W'(1);
              plane_d = plane_q + IA_W'(hw_q);
            end
          end else begin
            ky_d   = ky_q + K_W'(1);
            y_d    = y_q + SPAN_W'(1);
            yrow_d = yrow_q + w_ext;
          end
        end else begin
          kx_d = kx_q + K_W'(1);
          x_d  = x_q + SPAN_W'(1);
        end
      end
      S_DRAIN: begin
        // wait for the last read and product to land in the accumulator
        if (!rd_vld_q && !prod_vld_q) state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (bad_q) begin
            out_word_d.result = '0;
            out_word_d.status = STAT_RANGE;
          end else if (sat_hi) begin
            out_word_d.result = {1'b0, {(RES_W-1){1'b1}}};
            out_word_d.status = STAT_SAT;
          end else if (sat_lo) begin
            out_word_d.result = {1'b1, {(RES_W-1){1'b0}}};
            out_word_d.status = STAT_SAT;
          end else begin
            out_word_d.result = acc_q[RES_W-1:0];
            out_word_d.status = STAT_OK;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_vld_q    <= 1'b0;
      prod_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
      in_ch_q     <= 5'd1;
      out_ch_q    <= 5'd1;
      ksize_q     <= 3'd3;
      stride_q    <= 3'd1;
      pad_q       <= 2'd0;
      in_h_q      <= 7'd32;
      in_w_q      <= 7'd32;
    end else begin
      state_q     <= state_d;
      rd_vld_q    <= rd_vld_d;
      prod_vld_q  <= prod_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_IN_CH:   in_ch_q  <= cfg_data_i[4:0];
          REG_OUT_CH:  out_ch_q <= cfg_data_i[4:0];
          REG_KSIZE:   ksize_q  <= cfg_data_i[2:0];
          REG_STRIDE:  stride_q <= cfg_data_i[2:0];
          REG_PADDING: pad_q    <= cfg_data_i[1:0];
          REG_IN_H:    in_h_q   <= cfg_data_i[6:0];
          REG_IN_W:    in_w_q   <= cfg_data_i[6:0];
          default: begin
          end
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    oc_q       <= oc_d;
    orow_q     <= orow_d;
    ocol_q     <= ocol_d;
    icn_q      <= icn_d;
    ocn_q      <= ocn_d;
    k_q        <= k_d;
    s_q        <= s_d;
    p_q        <= p_d;
    h_q        <= h_d;
    w_q        <= w_d;
    rs_q       <= rs_d;
    cs_q       <= cs_d;
    ocicn_q    <= ocicn_d;
    hw_q       <= hw_d;
    kk_q       <= kk_d;
    bias_q     <= bias_d;
    bad_q      <= bad_d;
    y0_q       <= y0_d;
    x0_q       <= x0_d;
    y0w_q      <= y0w_d;
    wa_q       <= wa_d;
    y_q        <= y_d;
    x_q        <= x_d;
    yrow_q     <= yrow_d;
    plane_q    <= plane_d;
    ic_q       <= ic_d;
    ky_q       <= ky_d;
    kx_q       <= kx_d;
    prod_q     <= prod_d;
    acc_q      <= acc_d;
    out_word_q <= out_word_d;
  end

  // weight and image stores: one write port for loads, one registered read port for the tap walk
  always_ff @(posedge clk_i) begin
    if (wmem_we) weight_mem[WIDX_W'(in_word_i.index)] <= in_word_i.value;
    wrd_q <= weight_mem[wa_q[WIDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (imem_we) image_mem[IIDX_W'(in_word_i.index)] <= in_word_i.value;
    ird_q <= image_mem[ia[IIDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (bmem_we) bias_mem[BIDX_W'(in_word_i.index)] <= in_word_i.value;
  end

endmodule

`default_nettype wire
